// File: hw/rtl/asq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asq_pkg
// Types and constants shared by the sample address sequencer modules.
// ----------------------------------------------------------------------------
package asq_pkg;

    // Sample ROM size in bytes (at most 2 MiB, the reach of the 21-bit rom_address)
    localparam logic [24:0] ROM_BYTES   = 25'd2097152;
    // Start offset added when the upper bank is selected
    localparam logic [24:0] BANK_OFFSET = 25'h0100000;
    // Bank select bit in the written byte
    localparam int unsigned BANK_BIT    = 4;

    // Register offsets for a register write
    localparam logic [2:0] REG_START_LO = 3'd0;
    localparam logic [2:0] REG_START_HI = 3'd2;
    localparam logic [2:0] REG_END_LO   = 3'd3;
    localparam logic [2:0] REG_END_HI   = 3'd5;
    localparam logic [2:0] REG_PLAY     = 3'd6;

    typedef enum logic [1:0] {
        REQ_REG_WRITE = 2'd0,
        REQ_ACK       = 2'd1,
        REQ_BANK      = 2'd2,
        REQ_TICK      = 2'd3
    } t_req_type;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic       clock_level;
    } t_in_item;

    typedef struct packed {
        logic [20:0] rom_address;
        logic        fetch_valid;
        logic        nibble_select;
        logic        irq_request;
        logic        codec_reset;
        logic        playing;
    } t_out_item;

endpackage : asq_pkg
`default_nettype wire

// File: hw/rtl/asq_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asq_core
// Sequencer state registers and the per-item update/result logic.
// ----------------------------------------------------------------------------
module asq_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire asq_pkg::t_in_item i_item,
    output asq_pkg::t_out_item     o_result
);

    logic [23:0] r_start,     n_start;
    logic [23:0] r_end,       n_end;
    logic        r_upper,     n_upper;
    logic [24:0] r_play_addr, n_play_addr;
    logic [23:0] r_play_end,  n_play_end;
    logic        r_idle,      n_idle;
    logic        r_phase,     n_phase;
    logic        r_irq,       n_irq;
    logic        r_rst_line,  n_rst_line;

    logic [1:0]  w_end_lane;
    logic        w_done;

    assign w_end_lane = 2'(i_item.reg_offset - asq_pkg::REG_END_LO);
    // end address is inclusive
    assign w_done = (r_play_addr >= asq_pkg::ROM_BYTES) ||
                    (r_play_addr > {1'b0, r_play_end});

    // Next state and result for the item in the input register
    always_comb begin
        n_start     = r_start;
        n_end       = r_end;
        n_upper     = r_upper;
        n_play_addr = r_play_addr;
        n_play_end  = r_play_end;
        n_idle      = r_idle;
        n_phase     = r_phase;
        n_irq       = r_irq;
        n_rst_line  = r_rst_line;
        o_result.rom_address   = '0;
        o_result.fetch_valid   = 1'b0;
        o_result.nibble_select = 1'b0;

        case (asq_pkg::t_req_type'(i_item.req_type))
            asq_pkg::REQ_REG_WRITE: begin
                case (i_item.reg_offset) inside
                    [asq_pkg::REG_START_LO:asq_pkg::REG_START_HI]: begin
                        n_start[{i_item.reg_offset[1:0], 3'b000} +: 8] = i_item.write_data;
                    end
                    [asq_pkg::REG_END_LO:asq_pkg::REG_END_HI]: begin
                        n_end[{w_end_lane, 3'b000} +: 8] = i_item.write_data;
                    end
                    asq_pkg::REG_PLAY: begin
                        if (r_start < r_end) begin
                            n_idle      = 1'b0;
                            n_rst_line  = 1'b0;
                            n_play_addr = {1'b0, r_start} +
                                          (r_upper ? asq_pkg::BANK_OFFSET : 25'd0);
                            n_play_end  = r_end;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            asq_pkg::REQ_ACK: begin
                n_irq      = 1'b0;
                n_idle     = 1'b1;
                n_rst_line = 1'b1;
            end
            asq_pkg::REQ_BANK: begin
                n_upper = i_item.write_data[asq_pkg::BANK_BIT];
            end
            asq_pkg::REQ_TICK: begin
                if (i_item.clock_level && !r_idle) begin
                    if (w_done) begin
                        n_idle     = 1'b1;
                        n_rst_line = 1'b1;
                        n_irq      = 1'b1;
                        n_phase    = 1'b0;
                    end else begin
                        o_result.rom_address   = r_play_addr[20:0];
                        o_result.fetch_valid   = 1'b1;
                        o_result.nibble_select = r_phase;
                        n_phase                = ~r_phase;
                        // advance after the second nibble
                        if (r_phase) begin
                            n_play_addr = r_play_addr + 25'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.irq_request = n_irq;
        o_result.codec_reset = n_rst_line;
        o_result.playing     = ~n_idle;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_upper     <= 1'b0;
            r_play_addr <= '0;
            r_play_end  <= '0;
            r_idle      <= 1'b1;
            r_phase     <= 1'b0;
            r_irq       <= 1'b0;
            r_rst_line  <= 1'b1;
        end else if (i_en) begin
            r_start     <= n_start;
            r_end       <= n_end;
            r_upper     <= n_upper;
            r_play_addr <= n_play_addr;
            r_play_end  <= n_play_end;
            r_idle      <= n_idle;
            r_phase     <= n_phase;
            r_irq       <= n_irq;
            r_rst_line  <= n_rst_line;
        end
    end

endmodule : asq_core
`default_nettype wire

// File: hw/rtl/adpcm_sample_address_sequencer.sv
// Pipeline: an accepted item is held in the input register, and its result is
//   written to the output register once that register is empty or being taken.
// Throughput: one item per cycle while the receiver does not stall; the input
//   and output registers, split by the state update logic, advance together.
// Reset: synchronous active-low; clears both stages, idles the sequencer and
//   holds the codec in reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_sample_address_sequencer
// Sample-playback ROM address sequencer with a two-register item pipeline.
// ----------------------------------------------------------------------------
module adpcm_sample_address_sequencer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire asq_pkg::t_in_item  i_item,
    // result item channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output asq_pkg::t_out_item      o_item
);

    logic               r_in_valid;
    asq_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    asq_pkg::t_out_item r_out_item;

    logic               w_advance;
    logic               w_accept;
    asq_pkg::t_out_item w_result;

    // Pipeline moves when the output register is empty or being taken
    assign w_advance = !r_out_valid || !i_stall;
    assign o_stall   = r_in_valid && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_item;
        end
    end

    asq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (r_in_valid && w_advance),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_item <= w_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

endmodule : adpcm_sample_address_sequencer
`default_nettype wire

// File: bench/adpcm_sample_address_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adpcm_sample_address_sequencer_checker
// Watches both item channels of the sample address sequencer. Every accepted
// input item runs through a cycle-free model of the sequencer. Each accepted
// result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module adpcm_sample_address_sequencer_checker
    import asq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // input item channel
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    // result item channel
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    // status for the bench top
    output int unsigned    o_fail_count,
    output int unsigned    o_pending
);

    // Model copy of the sequencer state
    logic [23:0] start_addr;
    logic [23:0] end_addr;
    logic        bank_hi;
    logic [24:0] play_addr;
    logic [23:0] play_last;
    logic        idle;
    logic        phase;
    logic        irq;
    logic        codec_rst;

    t_out_item   fetch_q[$];
    int unsigned mismatches = 0;

    // Apply one item to the model state and return the result it causes
    function automatic t_out_item step_sequencer(input t_in_item it);
        t_out_item res;
        int unsigned lane;
        res = '0;
        case (t_req_type'(it.req_type))
            REQ_REG_WRITE: begin
                if (it.reg_offset <= REG_START_HI) begin
                    lane = it.reg_offset - REG_START_LO;
                    start_addr[8*lane +: 8] = it.write_data;
                end else if (it.reg_offset <= REG_END_HI) begin
                    lane = it.reg_offset - REG_END_LO;
                    end_addr[8*lane +: 8] = it.write_data;
                end else if (it.reg_offset == REG_PLAY) begin
                    // play only takes effect for a non-empty range
                    if (start_addr < end_addr) begin
                        idle      = 1'b0;
                        codec_rst = 1'b0;
                        play_addr = {1'b0, start_addr} + (bank_hi ? BANK_OFFSET : 25'd0);
                        play_last = end_addr;
                    end
                end
            end
            REQ_ACK: begin
                irq       = 1'b0;
                idle      = 1'b1;
                codec_rst = 1'b1;
            end
            REQ_BANK: begin
                bank_hi = it.write_data[BANK_BIT];
            end
            default: begin
                // high tick while playing: fetch a nibble or finish the sample
                if (it.clock_level && !idle) begin
                    if (play_addr >= ROM_BYTES || play_addr > {1'b0, play_last}) begin
                        idle      = 1'b1;
                        codec_rst = 1'b1;
                        irq       = 1'b1;
                        phase     = 1'b0;
                    end else begin
                        res.rom_address   = play_addr[20:0];
                        res.fetch_valid   = 1'b1;
                        res.nibble_select = phase;
                        phase             = ~phase;
                        if (!phase) begin
                            play_addr = play_addr + 25'd1;
                        end
                    end
                end
            end
        endcase
        res.irq_request = irq;
        res.codec_reset = codec_rst;
        res.playing     = !idle;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Predict on input acceptance, compare on result acceptance
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            start_addr = '0;
            end_addr   = '0;
            bank_hi    = 1'b0;
            play_addr  = '0;
            play_last  = '0;
            idle       = 1'b1;
            phase      = 1'b0;
            irq        = 1'b0;
            codec_rst  = 1'b1;
            fetch_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (fetch_q.size() == 0) begin
                    $error("result item with nothing expected: 0x%h", i_out_item);
                    mismatches++;
                end else begin
                    want = fetch_q.pop_front();
                    check_field("rom_address", want.rom_address, i_out_item.rom_address);
                    check_field("fetch_valid", want.fetch_valid, i_out_item.fetch_valid);
                    check_field("nibble_select", want.nibble_select,
                                i_out_item.nibble_select);
                    check_field("irq_request", want.irq_request, i_out_item.irq_request);
                    check_field("codec_reset", want.codec_reset, i_out_item.codec_reset);
                    check_field("playing", want.playing, i_out_item.playing);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fetch_q.push_back(step_sequencer(i_in_item));
            end
        end
        o_pending    <= fetch_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/tb_adpcm_sample_address_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adpcm_sample_address_sequencer
// Drives register, bank, acknowledge and codec tick items into the sequencer:
// a short directed pass over the corner cases, then random playback
// sequences mixed with noise. Both sides idle at random and the receiver
// holds off once for a long stretch. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_adpcm_sample_address_sequencer;
    import asq_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1450;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    t_in_item    in_item     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    t_out_item   out_item;
    logic        calm        = 1'b0;
    logic        squeeze_req = 1'b0;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned sent        = 0;
    int unsigned quiet_cycles = 0;

    always #2 clk = ~clk;

    adpcm_sample_address_sequencer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    adpcm_sample_address_sequencer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item after a random gap and wait until it is taken
    task automatic put_item(input t_req_type kind, input logic [2:0] off,
                            input logic [7:0] data, input logic level);
        t_in_item    it;
        int unsigned gap;
        int unsigned r;
        it.req_type    = kind;
        it.reg_offset  = off;
        it.write_data  = data;
        it.clock_level = level;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 30);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (!((kind == REQ_TICK && !level) || (kind == REQ_REG_WRITE && off == 3'd7))) begin
            sent++;
        end
    endtask

    task automatic reg_write(input logic [2:0] off, input logic [7:0] data);
        put_item(REQ_REG_WRITE, off, data, 1'($urandom));
    endtask

    task automatic play();
        reg_write(REG_PLAY, 8'($urandom));
    endtask

    task automatic tick(input logic level);
        put_item(REQ_TICK, 3'($urandom), 8'($urandom), level);
    endtask

    task automatic ack();
        put_item(REQ_ACK, 3'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic bank(input logic upper);
        logic [7:0] data;
        data           = 8'($urandom);
        data[BANK_BIT] = upper;
        put_item(REQ_BANK, 3'($urandom), data, 1'($urandom));
    endtask

    // Write a 24-bit address byte by byte, starting at a random lane
    task automatic load_addr(input logic [2:0] base, input logic [23:0] value);
        int unsigned first_lane;
        int unsigned lane;
        first_lane = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            lane = (first_lane + k) % 3;
            reg_write(base + 3'(lane), value[8*lane +: 8]);
        end
    endtask

    // Receiver: random stall runs, one long hold-off on request
    initial begin : receiver
        int unsigned left;
        logic        squeeze_done;
        left         = 0;
        squeeze_done = 1'b0;
        forever begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                left = 0;
            end else if (calm) begin
                out_stall <= 1'b0;
                left = 0;
            end else if (left == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    out_stall <= 1'b0;
                    left = $urandom_range(1, 20);
                end else begin
                    out_stall <= 1'b1;
                    left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 40);
                end
                left = left - 1;
            end else begin
                left = left - 1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        logic [23:0] first;
        logic [23:0] last;
        int unsigned ticks;
        int unsigned r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // ticks while idle, unused offset, play of an empty range
        tick(1'b1);
        tick(1'b0);
        reg_write(3'd7, 8'hFF);
        play();
        // run off the top of the ROM, low tick in the middle
        load_addr(REG_START_LO, 24'h1FFFFE);
        load_addr(REG_END_LO, 24'hFFFFFF);
        play();
        tick(1'b1);
        tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        tick(1'b1);
        tick(1'b1);
        ack();
        // upper bank moves the start past the ROM end
        bank(1'b1);
        play();
        tick(1'b1);
        ack();
        // restart while playing keeps the nibble phase
        bank(1'b0);
        play();
        tick(1'b1);
        play();
        tick(1'b1);
        ack();

        squeeze_req <= 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm <= ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 99) < 20) begin
                // noise burst over every field
                repeat ($urandom_range(1, 6)) begin
                    put_item(t_req_type'($urandom_range(0, 3)), 3'($urandom),
                             8'($urandom), 1'($urandom));
                end
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: first = 24'($urandom_range(0, 'h1FFFFF));
                    5, 6:          first = 24'($urandom_range('h1FFFF0, 'h1FFFFF));
                    7:             first = 24'($urandom_range('h0FFFF0, 'h0FFFFF));
                    8:             first = 24'($urandom);
                    default:       first = 24'($urandom_range(0, 15));
                endcase
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    last = first - 24'($urandom_range(0, 2));
                end else if (r < 12) begin
                    last = 24'hFFFFFF;
                end else begin
                    last = (first > 24'hFFFFF5) ? 24'hFFFFFF
                                                : first + 24'($urandom_range(0, 10));
                end
                if ($urandom_range(0, 1) == 0) begin
                    bank($urandom_range(0, 99) < 30);
                end
                load_addr(REG_START_LO, first);
                load_addr(REG_END_LO, last);
                play();
                if (last >= first && last - first < 16) begin
                    ticks = 2 * (last - first) + 2 + $urandom_range(1, 3);
                end else begin
                    ticks = $urandom_range(2, 30);
                end
                // ticks with the odd register write, restart or bank change
                for (int i = 0; i < ticks; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        reg_write(3'($urandom_range(0, 5)), 8'($urandom));
                    end else if (r < 9) begin
                        play();
                    end else if (r < 12) begin
                        bank(1'($urandom));
                    end else if (r < 25) begin
                        tick(1'b0);
                    end else begin
                        tick(1'b1);
                    end
                end
                if ($urandom_range(0, 99) < 85) begin
                    ack();
                end
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: adpcm_sample_address_sequencer.f
hw/rtl/asq_pkg.sv
hw/rtl/asq_core.sv
hw/rtl/adpcm_sample_address_sequencer.sv
bench/adpcm_sample_address_sequencer_checker.sv
bench/tb_adpcm_sample_address_sequencer.sv
